### design/sir_pkg.sv
// Shared types, constants and helper functions for the SIR epidemic automaton.
// No dependencies; every other file of the block imports this package.
package sir_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DIM_W = 7;
	localparam int THR_W = 17;
	localparam int CNT_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NB_W = 3;
	localparam int K_W = 4;
	localparam logic [31:0] DEFAULT_SEED = 32'd2463534242;

	typedef enum logic [2:0] {
		CELL_EMPTY     = 3'd0,
		CELL_HEALTHY   = 3'd1,
		CELL_INFECTED  = 3'd2,
		CELL_RECOVERED = 3'd3,
		CELL_DEAD      = 3'd4
	} cell_t;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_READ   = 2'd1,
		REQ_EVOLVE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS  = 3'd0,
		CFG_COLS  = 3'd1,
		CFG_INF   = 3'd2,
		CFG_REC   = 3'd3,
		CFG_DEATH = 3'd4,
		CFG_SEED  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DRAW_INF   = 2'd0,
		DRAW_REC   = 2'd1,
		DRAW_DEATH = 2'd2
	} draw_sel_t;

	typedef struct packed {
		logic      clr_step;
		logic      lat_req;
		logic      req_exec;
		logic      req_cap;
		logic      cell_rd;
		logic      cell_cap;
		logic      nb_rd;
		logic      nb_cap;
		logic      draw;
		draw_sel_t draw_sel;
		logic      cell_next;
		logic      cnt_step;
	} sir_cmd_t;

	typedef struct packed {
		logic  clr_done;
		req_t  req_type;
		logic  req_ok;
		cell_t cell_state;
		logic  nb_last;
		logic  nb_hit;
		logic  k_zero;
		logic  d_last;
		logic  draw_hit;
		logic  cell_last;
	} sir_stat_t;

	// xorshift32 with shifts 13, 17, 5
	function automatic logic [31:0] rng_next(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	// Row and column offsets of the eight neighbors, center skipped.
	function automatic logic [1:0] nb_drow(input logic [NB_W-1:0] n);
		logic [1:0] d;
		case (n)
			3'd0, 3'd1, 3'd2: d = 2'b11;
			3'd3, 3'd4:       d = 2'b00;
			default:          d = 2'b01;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nb_dcol(input logic [NB_W-1:0] n);
		logic [1:0] d;
		case (n)
			3'd0, 3'd3, 3'd5: d = 2'b11;
			3'd1, 3'd6:       d = 2'b00;
			default:          d = 2'b01;
		endcase
		return d;
	endfunction

endpackage

### design/sir_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sir_pkg for field widths.
interface sir_req_if;
	import sir_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [ROW_W-1:0]     row_index;
	logic [COL_W-1:0]     col_index;
	logic [2:0]           cell_value;
	modport source (output valid, req_type, row_index, col_index, cell_value, input ready);
	modport sink (input valid, req_type, row_index, col_index, cell_value, output ready);
endinterface

interface sir_rsp_if;
	import sir_pkg::*;
	logic             valid;
	logic             ready;
	logic [2:0]       read_value;
	logic             status;
	logic [CNT_W-1:0] healthy_count;
	logic [CNT_W-1:0] infected_count;
	logic [CNT_W-1:0] recovered_count;
	logic [CNT_W-1:0] dead_count;
	modport source (output valid, read_value, status, healthy_count, infected_count,
		recovered_count, dead_count, input ready);
	modport sink (input valid, read_value, status, healthy_count, infected_count,
		recovered_count, dead_count, output ready);
endinterface

### design/sir_datapath.sv
// Datapath: grid memory, generator, configuration, scan counters and cell counts.
// Depends on sir_pkg; driven by sir_ctrl through sir_cmd_t.
module sir_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sir_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sir_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [1:0]                    req_type,
	input  logic [sir_pkg::ROW_W-1:0]     row_index,
	input  logic [sir_pkg::COL_W-1:0]     col_index,
	input  logic [2:0]                    cell_value,
	input  sir_pkg::sir_cmd_t             cmd,
	output sir_pkg::sir_stat_t            stat,
	output logic [2:0]                    read_value,
	output logic                          status,
	output logic [sir_pkg::CNT_W-1:0]     healthy_count,
	output logic [sir_pkg::CNT_W-1:0]     infected_count,
	output logic [sir_pkg::CNT_W-1:0]     recovered_count,
	output logic [sir_pkg::CNT_W-1:0]     dead_count
);
	import sir_pkg::*;

	logic [2:0] mem [2**ADDR_W];

	logic [DIM_W-1:0] rows_q, cols_q, nr, nc;
	logic [THR_W-1:0] inf_thr_q, rec_thr_q, dth_thr_q, thr;
	logic [31:0]      rng_q, rng_n;
	logic             draw_hit;

	logic [ADDR_W-1:0] clr_q;
	req_t              rtype_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic [2:0]        rval_q;
	logic              req_ok;

	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic              cell_last;
	logic [NB_W-1:0]   nb_q;
	logic [K_W-1:0]    k_q, d_q;
	logic              nb_ok_s1, cnt_vld_s1, rec_hit_q;
	logic [1:0]        drow, dcol;
	logic [7:0]        nbr, nbc;
	logic              nb_ok;

	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [2:0]        wr_data, rd_data_q;

	logic [2:0]        read_q;
	logic              status_q;
	logic [CNT_W-1:0]  cnt_h_q, cnt_i_q, cnt_r_q, cnt_d_q;

	always_comb begin
		nr = (rows_q < DIM_W'(2)) ? DIM_W'(2) :
			(rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_q;
		nc = (cols_q < DIM_W'(2)) ? DIM_W'(2) :
			(cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_q;
	end

	always_comb begin
		unique case (cmd.draw_sel)
			DRAW_REC:   thr = rec_thr_q;
			DRAW_DEATH: thr = dth_thr_q;
			default:    thr = inf_thr_q;
		endcase
	end

	// A threshold of 65536 or more beats every 16-bit draw.
	assign rng_n    = rng_next(rng_q);
	assign draw_hit = {1'b0, rng_n[31:16]} < thr;

	assign req_ok    = ({1'b0, rrow_q} < nr) && ({1'b0, rcol_q} < nc);
	assign cell_last = ({1'b0, r_q} == nr - DIM_W'(1)) && ({1'b0, c_q} == nc - DIM_W'(1));

	assign drow  = nb_drow(nb_q);
	assign dcol  = nb_dcol(nb_q);
	assign nbr   = {{(8-ROW_W){1'b0}}, r_q} + {{6{drow[1]}}, drow};
	assign nbc   = {{(8-COL_W){1'b0}}, c_q} + {{6{dcol[1]}}, dcol};
	assign nb_ok = !nbr[7] && !nbc[7] && (nbr < {1'b0, nr}) && (nbc < {1'b0, nc});

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {r_q, c_q};
		if (cmd.req_exec && rtype_q == REQ_READ && req_ok) begin
			rd_en   = 1'b1;
			rd_addr = {rrow_q, rcol_q};
		end else if (cmd.nb_rd) begin
			rd_en   = 1'b1;
			rd_addr = {nbr[ROW_W-1:0], nbc[COL_W-1:0]};
		end else if (cmd.cell_rd || cmd.cnt_step) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {r_q, c_q};
		wr_data = CELL_EMPTY;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.req_exec && rtype_q == REQ_WRITE && req_ok) begin
			wr_en   = 1'b1;
			wr_addr = {rrow_q, rcol_q};
			wr_data = (rval_q > CELL_DEAD) ? CELL_EMPTY : rval_q;
		end else if (cmd.draw && cmd.draw_sel == DRAW_INF && draw_hit) begin
			wr_en   = 1'b1;
			wr_data = CELL_INFECTED;
		end else if (cmd.draw && cmd.draw_sel == DRAW_DEATH) begin
			wr_en   = 1'b1;
			wr_data = draw_hit ? CELL_DEAD : CELL_RECOVERED;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= DIM_W'(MAX_ROWS);
			cols_q    <= DIM_W'(MAX_COLS);
			inf_thr_q <= '0;
			rec_thr_q <= '0;
			dth_thr_q <= '0;
			rng_q     <= DEFAULT_SEED;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROWS:  rows_q    <= cfg_wdata[DIM_W-1:0];
				CFG_COLS:  cols_q    <= cfg_wdata[DIM_W-1:0];
				CFG_INF:   inf_thr_q <= cfg_wdata[THR_W-1:0];
				CFG_REC:   rec_thr_q <= cfg_wdata[THR_W-1:0];
				CFG_DEATH: dth_thr_q <= cfg_wdata[THR_W-1:0];
				CFG_SEED:  rng_q     <= (cfg_wdata == '0) ? DEFAULT_SEED : cfg_wdata;
				default:   ;
			endcase
		end else if (cmd.draw) begin
			rng_q <= rng_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			nb_q       <= '0;
			k_q        <= '0;
			d_q        <= '0;
			nb_ok_s1   <= 1'b0;
			cnt_vld_s1 <= 1'b0;
			rec_hit_q  <= 1'b0;
		end else begin
			cnt_vld_s1 <= cmd.cnt_step;
			if (cmd.clr_step) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.req_exec) begin
				r_q <= '0;
				c_q <= '0;
			end
			if (cmd.cell_next || cmd.cnt_step) begin
				if (cell_last) begin
					r_q <= '0;
					c_q <= '0;
				end else if ({1'b0, c_q} == nc - DIM_W'(1)) begin
					c_q <= '0;
					r_q <= r_q + ROW_W'(1);
				end else begin
					c_q <= c_q + COL_W'(1);
				end
			end
			if (cmd.cell_cap) begin
				nb_q <= '0;
				k_q  <= '0;
				d_q  <= '0;
			end
			if (cmd.nb_rd) nb_ok_s1 <= nb_ok;
			if (cmd.nb_cap) begin
				nb_q <= nb_q + NB_W'(1);
				if (stat.nb_hit) k_q <= k_q + K_W'(1);
			end
			if (cmd.draw && cmd.draw_sel == DRAW_INF) d_q <= d_q + K_W'(1);
			if (cmd.draw && cmd.draw_sel == DRAW_REC) rec_hit_q <= draw_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_req) begin
			rtype_q <= req_t'(req_type);
			rrow_q  <= row_index;
			rcol_q  <= col_index;
			rval_q  <= cell_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			status_q <= 1'b0;
			cnt_h_q  <= '0;
			cnt_i_q  <= '0;
			cnt_r_q  <= '0;
			cnt_d_q  <= '0;
		end else begin
			if (cmd.req_exec) begin
				read_q   <= '0;
				status_q <= (rtype_q == REQ_WRITE || rtype_q == REQ_READ) && !req_ok;
				cnt_h_q  <= '0;
				cnt_i_q  <= '0;
				cnt_r_q  <= '0;
				cnt_d_q  <= '0;
			end
			if (cmd.req_cap) read_q <= rd_data_q;
			if (cnt_vld_s1) begin
				case (rd_data_q)
					CELL_HEALTHY:   cnt_h_q <= cnt_h_q + CNT_W'(1);
					CELL_INFECTED:  cnt_i_q <= cnt_i_q + CNT_W'(1);
					CELL_RECOVERED: cnt_r_q <= cnt_r_q + CNT_W'(1);
					CELL_DEAD:      cnt_d_q <= cnt_d_q + CNT_W'(1);
					default:        ;
				endcase
			end
		end
	end

	always_comb begin
		stat.clr_done   = (clr_q == '1);
		stat.req_type   = rtype_q;
		stat.req_ok     = req_ok;
		stat.cell_state = cell_t'(rd_data_q);
		stat.nb_last    = (nb_q == '1);
		stat.nb_hit     = nb_ok_s1 && (rd_data_q == CELL_INFECTED);
		stat.k_zero     = (k_q == '0);
		stat.d_last     = (d_q == k_q);
		stat.draw_hit   = cmd.draw_sel == DRAW_DEATH ? rec_hit_q : draw_hit;
		stat.cell_last  = cell_last;
	end

	assign read_value      = read_q;
	assign status          = status_q;
	assign healthy_count   = cnt_h_q;
	assign infected_count  = cnt_i_q;
	assign recovered_count = cnt_r_q;
	assign dead_count      = cnt_d_q;

endmodule

### design/sir_ctrl.sv
// Controller state machine: clearing pass, request handling, evolve scan, count sweep.
// Depends on sir_pkg; commands sir_datapath through sir_cmd_t.
module sir_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sir_pkg::sir_stat_t stat,
	output sir_pkg::sir_cmd_t  cmd
);
	import sir_pkg::*;

	typedef enum logic [14:0] {
		ST_CLR      = 15'b000000000000001,
		ST_IDLE     = 15'b000000000000010,
		ST_REQ      = 15'b000000000000100,
		ST_RDCAP    = 15'b000000000001000,
		ST_CELL_RD  = 15'b000000000010000,
		ST_CELL_CHK = 15'b000000000100000,
		ST_NB_RD    = 15'b000000001000000,
		ST_NB_CAP   = 15'b000000010000000,
		ST_DRAW_REC = 15'b000000100000000,
		ST_DRAW_DTH = 15'b000001000000000,
		ST_DRAW_INF = 15'b000010000000000,
		ST_NEXT     = 15'b000100000000000,
		ST_CNT      = 15'b001000000000000,
		ST_CNT_END  = 15'b010000000000000,
		ST_OUT      = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.lat_req = 1'b1;
					state_d     = ST_REQ;
				end
			end
			ST_REQ: begin
				cmd.req_exec = 1'b1;
				if (stat.req_type == REQ_EVOLVE) state_d = ST_CELL_RD;
				else if (stat.req_type == REQ_READ && stat.req_ok) state_d = ST_RDCAP;
				else state_d = ST_CNT;
			end
			ST_RDCAP: begin
				cmd.req_cap = 1'b1;
				state_d     = ST_CNT;
			end
			ST_CELL_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = ST_CELL_CHK;
			end
			ST_CELL_CHK: begin
				cmd.cell_cap = 1'b1;
				if (stat.cell_state == CELL_INFECTED) state_d = ST_DRAW_REC;
				else if (stat.cell_state == CELL_HEALTHY) state_d = ST_NB_RD;
				else state_d = ST_NEXT;
			end
			ST_NB_RD: begin
				cmd.nb_rd = 1'b1;
				state_d   = ST_NB_CAP;
			end
			ST_NB_CAP: begin
				cmd.nb_cap = 1'b1;
				if (!stat.nb_last) state_d = ST_NB_RD;
				else if (stat.k_zero && !stat.nb_hit) state_d = ST_NEXT;
				else state_d = ST_DRAW_INF;
			end
			ST_DRAW_REC: begin
				cmd.draw     = 1'b1;
				cmd.draw_sel = DRAW_REC;
				state_d      = stat.draw_hit ? ST_DRAW_DTH : ST_NEXT;
			end
			ST_DRAW_DTH: begin
				cmd.draw     = 1'b1;
				cmd.draw_sel = DRAW_DEATH;
				state_d      = ST_NEXT;
			end
			ST_DRAW_INF: begin
				cmd.draw     = 1'b1;
				cmd.draw_sel = DRAW_INF;
				if (stat.draw_hit || stat.d_last) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.cell_next = 1'b1;
				state_d       = stat.cell_last ? ST_CNT : ST_CELL_RD;
			end
			ST_CNT: begin
				cmd.cnt_step = 1'b1;
				if (stat.cell_last) state_d = ST_CNT_END;
			end
			ST_CNT_END: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else         state_q <= state_d;
	end

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while a word is pending");
	a_accept_to_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_REQ) else $error("accepted word not executed");
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && stat.clr_done) |=> state_q == ST_IDLE)
		else $error("clearing pass did not end");

endmodule

### design/sir_epidemic_automaton_step.sv
// Top level of the SIR epidemic automaton: controller plus datapath.
// Depends on sir_pkg, sir_if, sir_ctrl and sir_datapath.
//
//   channel  direction  handshake     payload
//   req      in         valid/ready   req_type, row_index, col_index, cell_value
//   rsp      out        valid/ready   read_value, status, four state counts
//   cfg      in         cfg_we        cfg_idx, cfg_wdata
//
// One item at a time. Every request ends with a count sweep that reads each
// cell through the single grid read port, after a read has fetched its cell.
// An evolve first scans the grid cell by cell: read the cell, read a healthy
// cell's eight neighbors, make the draws, then step to the next cell.
// After reset a clearing pass zeroes every grid word before req is ready.
// A stalled rsp holds the block; req is not ready until the word is taken.
module sir_epidemic_automaton_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sir_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sir_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sir_req_if.sink                        req,
	sir_rsp_if.source                      rsp
);
	import sir_pkg::*;

	sir_cmd_t  cmd;
	sir_stat_t stat;

	sir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sir_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req.req_type),
		.row_index       (req.row_index),
		.col_index       (req.col_index),
		.cell_value      (req.cell_value),
		.cmd             (cmd),
		.stat            (stat),
		.read_value      (rsp.read_value),
		.status          (rsp.status),
		.healthy_count   (rsp.healthy_count),
		.infected_count  (rsp.infected_count),
		.recovered_count (rsp.recovered_count),
		.dead_count      (rsp.dead_count)
	);

endmodule

### verif/tb_sir_epidemic_automaton_step.sv
// Testbench for the SIR epidemic automaton: a directed table, then random phases
// under several grid sizes, thresholds, seeds and idling modes, each word checked
// against its table word or a predictor. Depends on sir_pkg, sir_if and the RTL.
module tb_sir_epidemic_automaton_step;
	timeunit 1ns;
	timeprecision 1ps;
	import sir_pkg::*;

	typedef struct packed {
		logic [2:0]       rd;
		logic             st;
		logic [CNT_W-1:0] hc;
		logic [CNT_W-1:0] ic;
		logic [CNT_W-1:0] rc;
		logic [CNT_W-1:0] dc;
	} rsp_word_t;

	typedef struct {
		bit         is_cfg;
		cfg_idx_t   idx;
		logic [31:0] wdata;
		req_t       rq;
		logic [5:0] row;
		logic [5:0] col;
		logic [2:0] val;
		bit         typed;
		rsp_word_t  word;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sir_req_if req ();
	sir_rsp_if rsp ();

	sir_epidemic_automaton_step i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// Predictor state
	logic [2:0]  grid [MAX_ROWS][MAX_COLS];
	logic [31:0] rng;
	logic [6:0]  rows_reg, cols_reg;
	logic [16:0] inf_thr, rec_thr, death_thr;

	rsp_word_t expected_words [$];
	step_row_t step_tab [$];
	int mismatches = 0;
	int idle_mode = 0;   // 0 none, 1 sender idle, 2 receiver stall, 3 both light

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int eff_rows();
		return (rows_reg < 2) ? 2 : (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int eff_cols();
		return (cols_reg < 2) ? 2 : (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	function automatic bit draw_below(input logic [16:0] thr);
		logic [31:0] x;
		logic [16:0] t;
		x = rng;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		rng = x;
		t = (thr > 17'd65536) ? 17'd65536 : thr;
		return {1'b0, x[31:16]} < t;
	endfunction

	function automatic void evolve_grid();
		int nr, nc, k, d;
		bit hit;
		nr = eff_rows();
		nc = eff_cols();
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				if (grid[r][c] == CELL_INFECTED) begin
					if (draw_below(rec_thr))
						grid[r][c] = draw_below(death_thr) ? CELL_DEAD : CELL_RECOVERED;
				end else if (grid[r][c] == CELL_HEALTHY) begin
					k = 0;
					for (int dr = -1; dr <= 1; dr++)
						for (int dc = -1; dc <= 1; dc++)
							if (!(dr == 0 && dc == 0) && r + dr >= 0 && c + dc >= 0 &&
									r + dr < nr && c + dc < nc &&
									grid[r + dr][c + dc] == CELL_INFECTED)
								k++;
					hit = 0;
					d = 0;
					while (k >= 1 && !hit && d <= k) begin
						hit = draw_below(inf_thr);
						d++;
					end
					if (hit)
						grid[r][c] = CELL_INFECTED;
				end
			end
		end
	endfunction

	function automatic rsp_word_t predict_step(input req_t rq, input logic [5:0] row,
			input logic [5:0] col, input logic [2:0] val);
		rsp_word_t w;
		int nr, nc;
		nr = eff_rows();
		nc = eff_cols();
		w = '0;
		if (rq == REQ_WRITE || rq == REQ_READ) begin
			if (row >= nr || col >= nc)
				w.st = 1'b1;
			else if (rq == REQ_WRITE)
				grid[row][col] = (val > CELL_DEAD) ? CELL_EMPTY : val;
			else
				w.rd = grid[row][col];
		end else if (rq == REQ_EVOLVE) begin
			evolve_grid();
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				case (grid[r][c])
					CELL_HEALTHY:   w.hc++;
					CELL_INFECTED:  w.ic++;
					CELL_RECOVERED: w.rc++;
					CELL_DEAD:      w.dc++;
					default: ;
				endcase
		return w;
	endfunction

	function automatic void apply_reg(input cfg_idx_t idx, input logic [31:0] v);
		case (idx)
			CFG_ROWS:  rows_reg = v[6:0];
			CFG_COLS:  cols_reg = v[6:0];
			CFG_INF:   inf_thr = v[16:0];
			CFG_REC:   rec_thr = v[16:0];
			CFG_DEATH: death_thr = v[16:0];
			CFG_SEED:  rng = (v == 0) ? DEFAULT_SEED : v;
			default: ;
		endcase
	endfunction

	function automatic void add_item(input req_t rq, input int row, input int col,
			input int val, input bit typed = 0, input int rd = 0, input int st = 0,
			input int hc = 0, input int ic = 0, input int rc = 0, input int dc = 0);
		step_row_t s;
		s.is_cfg = 1'b0;
		s.idx = CFG_ROWS;
		s.wdata = '0;
		s.rq = rq;
		s.row = 6'(row);
		s.col = 6'(col);
		s.val = 3'(val);
		s.typed = typed;
		s.word = '{rd: 3'(rd), st: 1'(st), hc: CNT_W'(hc), ic: CNT_W'(ic),
			rc: CNT_W'(rc), dc: CNT_W'(dc)};
		step_tab = {step_tab, s};
	endfunction

	function automatic void add_cfg(input cfg_idx_t idx, input logic [31:0] v);
		step_row_t s;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.wdata = v;
		s.rq = REQ_NONE;
		s.row = '0;
		s.col = '0;
		s.val = '0;
		s.typed = 1'b0;
		s.word = '0;
		step_tab = {step_tab, s};
	endfunction

	// Registers change only with nothing in flight.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
		wait (expected_words.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = v;
		apply_reg(idx, v);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_word(input req_t rq, input logic [5:0] row, input logic [5:0] col,
			input logic [2:0] val, input bit typed, input rsp_word_t typed_word);
		rsp_word_t w;
		while ((idle_mode == 1 && $urandom_range(99) < 85) ||
				(idle_mode == 3 && $urandom_range(99) < 13)) begin
			req.valid = 0;
			@(negedge clk);
		end
		req.valid = 1;
		req.req_type = rq;
		req.row_index = row;
		req.col_index = col;
		req.cell_value = val;
		do @(posedge clk); while (!req.ready);
		w = predict_step(rq, row, col, val);
		expected_words = {expected_words, typed ? typed_word : w};
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic send_random(input int nr, input int nc);
		int p;
		req_t rq;
		logic [5:0] row, col;
		logic [2:0] val;
		p = $urandom_range(99);
		rq = (p < 45) ? REQ_WRITE : (p < 70) ? REQ_READ : (p < 95) ? REQ_EVOLVE : REQ_NONE;
		if ($urandom_range(99) < 15) begin
			row = 6'($urandom_range(63));
			col = 6'($urandom_range(63));
		end else begin
			row = 6'($urandom_range(nr - 1));
			col = 6'($urandom_range(nc - 1));
		end
		p = $urandom_range(99);
		val = (p < 40) ? CELL_HEALTHY : (p < 65) ? CELL_INFECTED : 3'($urandom_range(7));
		send_word(rq, row, col, val, 0, '0);
	endtask

	function automatic logic [31:0] pick_thr();
		case ($urandom_range(5))
			0: return 0;
			1: return 65536;
			2: return 131071;
			default: return $urandom_range(65535);
		endcase
	endfunction

	// Result side: stall per idling mode, compare each accepted word.
	initial begin
		rsp_word_t got, want;
		rsp.ready = 0;
		forever begin
			@(negedge clk);
			rsp.ready = !((idle_mode == 2 && $urandom_range(99) < 85) ||
				(idle_mode == 3 && $urandom_range(99) < 13));
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got = '{rd: rsp.read_value, st: rsp.status, hc: rsp.healthy_count,
					ic: rsp.infected_count, rc: rsp.recovered_count, dc: rsp.dead_count};
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %p", got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	initial begin
		int nr, nc;
		cfg_we = 0;
		cfg_idx = CFG_ROWS;
		cfg_wdata = 0;
		req.valid = 0;
		req.req_type = REQ_NONE;
		req.row_index = 0;
		req.col_index = 0;
		req.cell_value = 0;
		arst_n = 0;
		for (int r = 0; r < MAX_ROWS; r++)
			for (int c = 0; c < MAX_COLS; c++)
				grid[r][c] = CELL_EMPTY;
		rows_reg = 64;
		cols_reg = 64;
		inf_thr = 0;
		rec_thr = 0;
		death_thr = 0;
		rng = DEFAULT_SEED;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part, starting from the reset settings.
		add_item(REQ_READ, 0, 0, 0, 1);
		add_item(REQ_WRITE, 63, 63, CELL_HEALTHY, 1, 0, 0, 1);
		add_item(REQ_WRITE, 0, 0, CELL_INFECTED, 1, 0, 0, 1, 1);
		add_item(REQ_WRITE, 1, 1, 7, 1, 0, 0, 1, 1);
		add_item(REQ_READ, 63, 63, 0, 1, CELL_HEALTHY, 0, 1, 1);
		add_item(REQ_NONE, 63, 63, 7, 1, 0, 0, 1, 1);
		add_item(REQ_WRITE, 0, 1, CELL_HEALTHY);
		add_item(REQ_WRITE, 0, 2, CELL_RECOVERED);
		add_item(REQ_WRITE, 1, 0, CELL_DEAD);
		add_item(REQ_EVOLVE, 0, 0, 0);  // zero thresholds: nothing may change
		add_cfg(CFG_ROWS, 0);
		add_cfg(CFG_COLS, 127);
		add_cfg(CFG_INF, 65536);
		add_cfg(CFG_REC, 131071);
		add_cfg(CFG_DEATH, 131071);
		add_cfg(CFG_SEED, 0);
		add_item(REQ_READ, 2, 0, 0, 1, 0, 1, 1, 1, 1, 1);
		add_item(REQ_WRITE, 1, 63, CELL_INFECTED);
		add_item(REQ_WRITE, 0, 62, CELL_HEALTHY);
		add_item(REQ_EVOLVE, 0, 0, 0);
		add_cfg(CFG_ROWS, 64);
		add_cfg(CFG_COLS, 2);
		add_cfg(CFG_REC, 0);
		add_cfg(CFG_SEED, 32'hFFFF_FFFF);
		add_item(REQ_WRITE, 5, 2, CELL_INFECTED);
		add_item(REQ_WRITE, 1, 1, CELL_INFECTED);
		add_item(REQ_WRITE, 2, 0, CELL_HEALTHY);
		add_item(REQ_EVOLVE, 0, 0, 0);
		add_item(REQ_READ, 63, 1, 0);

		foreach (step_tab[n]) begin
			if (step_tab[n].is_cfg)
				write_reg(step_tab[n].idx, step_tab[n].wdata);
			else
				send_word(step_tab[n].rq, step_tab[n].row, step_tab[n].col,
					step_tab[n].val, step_tab[n].typed, step_tab[n].word);
		end

		// Random phases on small grids, one on the full grid.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_ROWS, (ph == 5) ? 127 : $urandom_range(1, 8));
			write_reg(CFG_COLS, (ph == 5) ? 64 : $urandom_range(0, 8));
			write_reg(CFG_INF, pick_thr());
			write_reg(CFG_REC, pick_thr());
			write_reg(CFG_DEATH, pick_thr());
			write_reg(CFG_SEED, $urandom());
			idle_mode = ph % 4;
			nr = eff_rows();
			nc = eff_cols();
			repeat ((ph == 5) ? 6 : 15)
				send_random(nr, nc);
		end

		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
